@@ rtl/core/tfn_pkg.sv @@
// Shared widths and constants for the triangle face normal block.
`timescale 1ns / 1ps
package tfn_pkg;

    localparam int MAG_W        = 31;
    localparam int SQ_W         = 2 * MAG_W;
    localparam int SUM_W        = 64;
    localparam int ONE_SHIFT    = 14;
    localparam int Q_W          = ONE_SHIFT + 1;
    localparam int NRM_W        = 16;
    localparam int M_W          = SQ_W + 30;
    localparam int ACC_W        = 98;
    localparam int SEARCH_STEPS = Q_W;
    localparam int OUT_W        = 3 * NRM_W + 1;

    localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << ONE_SHIFT;

    typedef logic signed [ACC_W-1:0] t_acc;

endpackage

@@ rtl/core/tfn_fifo.sv @@
// Small register queue with first-word-fall-through read.
`timescale 1ns / 1ps
module tfn_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en && !rd_en |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not advance on push");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");

endmodule

@@ rtl/core/tfn_front.sv @@
// Front end: edge vectors, exact cross product and degenerate detection.
`timescale 1ns / 1ps
module tfn_front
    import tfn_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic signed [COORD_WIDTH-1:0] i_ax,
    input  logic signed [COORD_WIDTH-1:0] i_ay,
    input  logic signed [COORD_WIDTH-1:0] i_az,
    input  logic signed [COORD_WIDTH-1:0] i_bx,
    input  logic signed [COORD_WIDTH-1:0] i_by_coord,
    input  logic signed [COORD_WIDTH-1:0] i_bz,
    input  logic signed [COORD_WIDTH-1:0] i_cx,
    input  logic signed [COORD_WIDTH-1:0] i_cy,
    input  logic signed [COORD_WIDTH-1:0] i_cz,
    output logic                         o_push,
    input  logic                         i_full,
    output logic [3*(2*COORD_WIDTH+3)-1:0] o_cross,
    output logic                         o_degenerate
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;
    localparam int CW = PW + 1;

    logic signed [DW-1:0] r_u [3];
    logic signed [DW-1:0] r_v [3];
    logic signed [PW-1:0] r_p [6];
    logic signed [CW-1:0] r_c [3];
    logic                 r_vld1;
    logic                 r_vld2;
    logic                 r_vld3;
    logic                 en;

    assign en     = !(r_vld3 && i_full);
    assign o_full = !en;
    assign o_push = r_vld3 && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else if (en) begin
            r_vld1 <= i_push;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_u[0] <= {i_bx[COORD_WIDTH-1], i_bx} - {i_ax[COORD_WIDTH-1], i_ax};
            r_u[1] <= {i_by_coord[COORD_WIDTH-1], i_by_coord} - {i_ay[COORD_WIDTH-1], i_ay};
            r_u[2] <= {i_bz[COORD_WIDTH-1], i_bz} - {i_az[COORD_WIDTH-1], i_az};
            r_v[0] <= {i_cx[COORD_WIDTH-1], i_cx} - {i_ax[COORD_WIDTH-1], i_ax};
            r_v[1] <= {i_cy[COORD_WIDTH-1], i_cy} - {i_ay[COORD_WIDTH-1], i_ay};
            r_v[2] <= {i_cz[COORD_WIDTH-1], i_cz} - {i_az[COORD_WIDTH-1], i_az};
            r_p[0] <= r_u[1] * r_v[2];
            r_p[1] <= r_u[2] * r_v[1];
            r_p[2] <= r_u[2] * r_v[0];
            r_p[3] <= r_u[0] * r_v[2];
            r_p[4] <= r_u[0] * r_v[1];
            r_p[5] <= r_u[1] * r_v[0];
            r_c[0] <= {r_p[0][PW-1], r_p[0]} - {r_p[1][PW-1], r_p[1]};
            r_c[1] <= {r_p[2][PW-1], r_p[2]} - {r_p[3][PW-1], r_p[3]};
            r_c[2] <= {r_p[4][PW-1], r_p[4]} - {r_p[5][PW-1], r_p[5]};
        end
    end

    assign o_cross      = {r_c[2], r_c[1], r_c[0]};
    assign o_degenerate = (r_c[0] == '0) && (r_c[1] == '0) && (r_c[2] == '0);

endmodule

@@ rtl/core/tfn_back.sv @@
// Back end: block scaling, squares and bit-by-bit rounded unit normal.
`timescale 1ns / 1ps
module tfn_back
    import tfn_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_empty,
    output logic                           o_pop,
    input  logic [3*(2*COORD_WIDTH+3)-1:0] i_cross,
    input  logic                           i_degenerate,
    output logic                           o_push,
    input  logic                           i_full,
    output logic [OUT_W-1:0]               o_data
);

    localparam int CW = 2 * COORD_WIDTH + 3;
    localparam int MW = CW - 1;
    localparam int LW = $clog2(MW + 1);
    localparam int PRE = 4;
    localparam int NB = PRE + SEARCH_STEPS;

    logic             r_vld [NB];
    logic             r_deg [NB];
    logic [2:0]       r_neg [NB];
    logic [MW-1:0]    r_mag [3];
    logic [MAG_W-1:0] r_m [3];
    logic [SQ_W-1:0]  r_sq [3];
    logic [SUM_W-1:0] r_s [SEARCH_STEPS+1];
    t_acc             r_p [SEARCH_STEPS+1][3];
    t_acc             r_t [SEARCH_STEPS+1][3];
    logic [M_W-1:0]   r_mm [SEARCH_STEPS+1][3];
    logic [Q_W-1:0]   r_q [SEARCH_STEPS+1][3];
    logic             en;
    logic [MW-1:0]    or_v;
    logic [LW-1:0]    len;
    logic [LW-1:0]    sh;
    logic [MW-1:0]    shifted [3];
    logic signed [CW-1:0] cin [3];
    logic [NRM_W-1:0] nrm [3];

    assign en    = !(r_vld[NB-1] && i_full);
    assign o_pop = en && !i_empty;
    assign o_push = r_vld[NB-1] && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NB; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= !i_empty;
            for (int i = 1; i < NB; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            cin[c] = i_cross[c*CW +: CW];
        end
        or_v = r_mag[0] | r_mag[1] | r_mag[2];
        len  = '0;
        for (int i = 0; i < MW; i++) begin
            if (or_v[i]) begin
                len = LW'(i + 1);
            end
        end
        sh = '0;
        if (int'(len) > MAG_W) begin
            sh = len - LW'(MAG_W);
        end
        for (int c = 0; c < 3; c++) begin
            shifted[c] = r_mag[c] >> sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_deg[0] <= i_degenerate;
            for (int c = 0; c < 3; c++) begin
                r_neg[0][c] <= cin[c][CW-1];
                r_mag[c]    <= cin[c][CW-1] ? MW'(-cin[c]) : MW'(cin[c]);
                r_m[c]      <= MAG_W'(shifted[c]);
                r_sq[c]     <= SQ_W'(r_m[c]) * SQ_W'(r_m[c]);
            end
            for (int i = 1; i < NB; i++) begin
                r_deg[i] <= r_deg[i-1];
                r_neg[i] <= r_neg[i-1];
            end
            r_s[0] <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
            for (int c = 0; c < 3; c++) begin
                r_p[0][c]  <= $signed({{(ACC_W-SUM_W){1'b0}},
                    SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2])});
                r_t[0][c]  <= -$signed({{(ACC_W-SUM_W){1'b0}},
                    SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2])});
                r_mm[0][c] <= {r_sq[c], 30'b0};
                r_q[0][c]  <= '0;
            end
        end
    end

    for (genvar j = 0; j < SEARCH_STEPS; j++) begin : g_step
        localparam int K = SEARCH_STEPS - 1 - j;
        t_acc s_ext;
        t_acc cand [3];
        logic take [3];

        assign s_ext = $signed({{(ACC_W-SUM_W){1'b0}}, r_s[j]});

        always_comb begin
            for (int c = 0; c < 3; c++) begin
                cand[c] = r_p[j][c] + (r_t[j][c] <<< (K + 2)) + (s_ext <<< (2 * K + 2));
                take[c] = cand[c] <= $signed({{(ACC_W-M_W){1'b0}}, r_mm[j][c]});
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_s[j+1] <= r_s[j];
                for (int c = 0; c < 3; c++) begin
                    r_mm[j+1][c] <= r_mm[j][c];
                    if (take[c]) begin
                        r_p[j+1][c] <= cand[c];
                        r_t[j+1][c] <= r_t[j][c] + (s_ext <<< (K + 1));
                        r_q[j+1][c] <= r_q[j][c] | (Q_W'(1) << K);
                    end else begin
                        r_p[j+1][c] <= r_p[j][c];
                        r_t[j+1][c] <= r_t[j][c];
                        r_q[j+1][c] <= r_q[j][c];
                    end
                end
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (r_deg[NB-1]) begin
                nrm[c] = '0;
            end else if (r_neg[NB-1][c]) begin
                nrm[c] = -NRM_W'(r_q[SEARCH_STEPS][c]);
            end else begin
                nrm[c] = NRM_W'(r_q[SEARCH_STEPS][c]);
            end
        end
    end

    assign o_data = {r_deg[NB-1], nrm[2], nrm[1], nrm[0]};

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NB-1] && !en |=> r_vld[NB-1])
        else $error("result dropped while output stalled");
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NB-1] && !r_deg[NB-1] |->
        r_q[SEARCH_STEPS][0] <= Q_ONE && r_q[SEARCH_STEPS][1] <= Q_ONE
        && r_q[SEARCH_STEPS][2] <= Q_ONE)
        else $error("normal component above one");

endmodule

@@ rtl/core/triangle_face_normal.sv @@
// Top level of the triangle face normal unit.
//
//  channel   ports                       direction  handshake
//  triangle  i_ax .. i_cz                in         push / full
//  normal    o_nx o_ny o_nz o_degenerate out        empty / pop
//
// One triangle enters and one normal leaves per cycle in steady state, while no queue is full.
// After its request is accepted, a result passes through three front stages,
// the middle queue, four scaling stages, fifteen rounding steps (one result
// bit each) and the output queue, 24 register stages, to the output ports.
// Reset clears all valid flags and queue pointers.
// A full output queue stalls the back end; a full middle queue stalls the
// front end and raises full.
`timescale 1ns / 1ps
module triangle_face_normal
    import tfn_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int MID_DEPTH   = 4,
    parameter int OUT_DEPTH   = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [COORD_WIDTH-1:0] i_ax,
    input  logic signed [COORD_WIDTH-1:0] i_ay,
    input  logic signed [COORD_WIDTH-1:0] i_az,
    input  logic signed [COORD_WIDTH-1:0] i_bx,
    input  logic signed [COORD_WIDTH-1:0] i_by_coord,
    input  logic signed [COORD_WIDTH-1:0] i_bz,
    input  logic signed [COORD_WIDTH-1:0] i_cx,
    input  logic signed [COORD_WIDTH-1:0] i_cy,
    input  logic signed [COORD_WIDTH-1:0] i_cz,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [NRM_W-1:0]       o_nx,
    output logic signed [NRM_W-1:0]       o_ny,
    output logic signed [NRM_W-1:0]       o_nz,
    output logic                          o_degenerate
);

    localparam int CW  = 2 * COORD_WIDTH + 3;
    localparam int QW  = 3 * CW + 1;

    logic              f_push;
    logic              f_full;
    logic [3*CW-1:0]   f_cross;
    logic              f_deg;
    logic              m_empty;
    logic              m_pop;
    logic [QW-1:0]     m_data;
    logic              b_push;
    logic              b_full;
    logic [OUT_W-1:0]  b_data;
    logic [OUT_W-1:0]  o_data;

    tfn_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_ax         (i_ax),
        .i_ay         (i_ay),
        .i_az         (i_az),
        .i_bx         (i_bx),
        .i_by_coord   (i_by_coord),
        .i_bz         (i_bz),
        .i_cx         (i_cx),
        .i_cy         (i_cy),
        .i_cz         (i_cz),
        .o_push       (f_push),
        .i_full       (f_full),
        .o_cross      (f_cross),
        .o_degenerate (f_deg)
    );

    tfn_fifo #(.WIDTH(QW), .DEPTH(MID_DEPTH)) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .o_full  (f_full),
        .i_data  ({f_deg, f_cross}),
        .i_pop   (m_pop),
        .o_empty (m_empty),
        .o_data  (m_data)
    );

    tfn_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (m_empty),
        .o_pop        (m_pop),
        .i_cross      (m_data[3*CW-1:0]),
        .i_degenerate (m_data[QW-1]),
        .o_push       (b_push),
        .i_full       (b_full),
        .o_data       (b_data)
    );

    tfn_fifo #(.WIDTH(OUT_W), .DEPTH(OUT_DEPTH)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (b_push),
        .o_full  (b_full),
        .i_data  (b_data),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (o_data)
    );

    assign o_nx         = o_data[NRM_W-1:0];
    assign o_ny         = o_data[2*NRM_W-1:NRM_W];
    assign o_nz         = o_data[3*NRM_W-1:2*NRM_W];
    assign o_degenerate = o_data[OUT_W-1];

endmodule
